// ----- rtl/core/mlr_pkg.sv -----
// Package for the midpoint line rasterizer core: coordinate widths,
// beat structs, line state and the shared pixel output function.
// No dependencies.
package mlr_pkg;

	localparam int CoordBits = 11;
	localparam int CW        = CoordBits + 1;  // working coordinate, holds a mirrored row
	localparam int DW        = CoordBits + 4;  // decision variable
	localparam int IW        = CoordBits + 3;  // decision increments

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [CoordBits-1:0] start_x;
		logic [CoordBits-1:0] start_y;
		logic [CoordBits-1:0] end_x;
		logic [CoordBits-1:0] end_y;
	} cmd_t;

	typedef struct packed {
		logic [CoordBits-1:0] pixel_x;
		logic [CoordBits-1:0] pixel_y;
		logic                 pixel_valid;
		logic                 last_pixel;
	} pix_t;

	typedef struct packed {
		logic [CW-1:0]        cur_x;
		logic [CW-1:0]        cur_y;
		logic [CW-1:0]        major_end;
		logic [CW-1:0]        base_row;
		logic signed [DW-1:0] decision;
		logic signed [IW-1:0] incr_straight;
		logic signed [IW-1:0] incr_diagonal;
		logic                 steep_mode;
		logic                 mirror_mode;
		logic                 line_active;
	} line_t;

	// Emit the current position, undoing the mirror about the start row.
	function automatic pix_t put_pixel(line_t s);
		logic [CW-1:0] oy;
		logic [CW-1:0] major;
		pix_t          p;
		oy    = s.mirror_mode ? (s.base_row + s.base_row - s.cur_y) : s.cur_y;
		major = s.steep_mode ? s.cur_y : s.cur_x;
		p.pixel_x     = s.cur_x[CoordBits-1:0];
		p.pixel_y     = oy[CoordBits-1:0];
		p.pixel_valid = 1'b1;
		p.last_pixel  = (major >= s.major_end);
		return p;
	endfunction

endpackage

// ----- rtl/core/mlr_setup.sv -----
// Line setup for the midpoint line rasterizer: orders and mirrors the
// endpoints, derives the decision terms and the first pixel.
// Depends on mlr_pkg.
module mlr_setup (
	input  mlr_pkg::cmd_t  cmd,
	output mlr_pkg::line_t line,
	output mlr_pkg::pix_t  pix
);

	logic [mlr_pkg::CoordBits-1:0] x0, y0, x1, y1, dx;
	logic                          swap, mirror, vert_swap, steep;
	logic [mlr_pkg::CW-1:0]        y0f, y1f, dy;
	logic signed [mlr_pkg::DW-1:0] dxs, dys, diag_w, straight_w, dec_w;
	mlr_pkg::line_t                lt;
	mlr_pkg::pix_t                 first;

	always_comb begin
		// swap endpoints so x rises
		swap = cmd.end_x < cmd.start_x;
		x0   = swap ? cmd.end_x   : cmd.start_x;
		y0   = swap ? cmd.end_y   : cmd.start_y;
		x1   = swap ? cmd.start_x : cmd.end_x;
		y1   = swap ? cmd.start_y : cmd.end_y;
		dx   = x1 - x0;

		mirror    = (dx != '0) && (y1 < y0);
		vert_swap = (dx == '0) && (y1 < y0);

		y0f = vert_swap ? {1'b0, y1} : {1'b0, y0};
		if (mirror) begin
			y1f = {1'b0, y0} + {1'b0, y0} - {1'b0, y1};
		end else if (vert_swap) begin
			y1f = {1'b0, y0};
		end else begin
			y1f = {1'b0, y1};
		end
		dy    = y1f - y0f;
		steep = dy > {1'b0, dx};

		dxs = $signed({{(mlr_pkg::DW - mlr_pkg::CoordBits){1'b0}}, dx});
		dys = $signed({{(mlr_pkg::DW - mlr_pkg::CW){1'b0}}, dy});

		diag_w = (dys - dxs) <<< 1;
		if (steep) begin
			dec_w      = dys - (dxs <<< 1);
			straight_w = -(dxs <<< 1);
		end else begin
			dec_w      = (dys <<< 1) - dxs;
			straight_w = dys <<< 1;
		end

		lt.cur_x         = {1'b0, x0};
		lt.cur_y         = y0f;
		lt.base_row      = y0f;
		lt.major_end     = steep ? y1f : {1'b0, x1};
		lt.decision      = dec_w;
		lt.incr_straight = straight_w[mlr_pkg::IW-1:0];
		lt.incr_diagonal = diag_w[mlr_pkg::IW-1:0];
		lt.steep_mode    = steep;
		lt.mirror_mode   = mirror;
		lt.line_active   = 1'b0;

		first          = mlr_pkg::put_pixel(lt);
		lt.line_active = !first.last_pixel;
		line           = lt;
		pix            = first;
	end

endmodule

// ----- rtl/core/mlr_step.sv -----
// Step unit for the midpoint line rasterizer: one decision update and one
// pixel along the major axis.
// Depends on mlr_pkg.
module mlr_step (
	input  mlr_pkg::line_t cur,
	output mlr_pkg::line_t nxt,
	output mlr_pkg::pix_t  pix
);

	logic                          pos, straight;
	logic signed [mlr_pkg::IW-1:0] inc;
	mlr_pkg::line_t                lt;
	mlr_pkg::pix_t                 p;

	always_comb begin
		pos      = cur.decision > 0;
		// shallow steps straight on a tie, steep steps diagonal on a tie
		straight = cur.steep_mode ? pos : !pos;
		inc      = straight ? cur.incr_straight : cur.incr_diagonal;

		lt          = cur;
		lt.decision = cur.decision
			+ $signed({{(mlr_pkg::DW - mlr_pkg::IW){inc[mlr_pkg::IW-1]}}, inc});
		if (cur.steep_mode) begin
			lt.cur_y = cur.cur_y + mlr_pkg::CW'(1);
			lt.cur_x = cur.cur_x + {{(mlr_pkg::CW-1){1'b0}}, !straight};
		end else begin
			lt.cur_x = cur.cur_x + mlr_pkg::CW'(1);
			lt.cur_y = cur.cur_y + {{(mlr_pkg::CW-1){1'b0}}, !straight};
		end

		p              = mlr_pkg::put_pixel(lt);
		lt.line_active = !p.last_pixel;

		if (cur.line_active) begin
			nxt = lt;
			pix = p;
		end else begin
			// idle: hold state, answer with an empty beat
			nxt = cur;
			pix = '0;
		end
	end

endmodule

// ----- rtl/core/midpoint_line_rasterizer_core.sv -----
// Top level of the midpoint line rasterizer: command register, line state,
// setup and step units, pixel output register.
// Depends on mlr_pkg, mlr_setup, mlr_step.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+-----------------------------
//   cmd     | in        | cmd_valid/cmd_stall  | mlr_pkg::cmd_t (load or step)
//   pix     | out       | pix_valid/pix_stall  | mlr_pkg::pix_t (one per cmd)
//
// One command beat per cycle sustained while pix is not stalled; each taken beat
// yields one pixel beat through the command register, then the pixel register.
// The line state loop is one add and compare, closed through the line state register.
// arst_n clears the line state to idle and empties both registers.
// pix_stall holds the pixel register; a held command then stalls cmd,
// so at most one command waits behind a waiting pixel.
module midpoint_line_rasterizer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  mlr_pkg::cmd_t  cmd,
	output logic           pix_valid,
	input  logic           pix_stall,
	output mlr_pkg::pix_t  pix
);

	mlr_pkg::cmd_t  cmd_s1;
	logic           valid_s1;
	mlr_pkg::line_t line_q;
	mlr_pkg::pix_t  pix_s2;
	logic           valid_s2;

	mlr_pkg::line_t setup_line, step_line, next_line;
	mlr_pkg::pix_t  setup_pix, step_pix, next_pix;
	logic           adv_s1, accept;

	mlr_setup u_setup (
		.cmd  (cmd_s1),
		.line (setup_line),
		.pix  (setup_pix)
	);

	mlr_step u_step (
		.cur (line_q),
		.nxt (step_line),
		.pix (step_pix)
	);

	// advance the held command when the pixel register is free or draining
	assign adv_s1    = valid_s1 && (!valid_s2 || !pix_stall);
	assign cmd_stall = valid_s1 && !adv_s1;
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		if (cmd_s1.action == mlr_pkg::ACT_LOAD) begin
			next_line = setup_line;
			next_pix  = setup_pix;
		end else begin
			next_line = step_line;
			next_pix  = step_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			line_q   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				line_q   <= next_line;
			end else if (!pix_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (adv_s1) begin
			pix_s2 <= next_pix;
		end
	end

	assign pix_valid = valid_s2;
	assign pix       = pix_s2;

endmodule

// ----- tb/midpoint_line_rasterizer_core_tb.sv -----
// Testbench for midpoint_line_rasterizer_core: directed and random line commands, with a
// scoreboard that predicts every pixel beat and checks it against the block's output.
// Depends on mlr_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module midpoint_line_rasterizer_core_tb;
	import mlr_pkg::*;

	localparam int QUIET_LIMIT = 3000;   // cycles with no beat on either side
	localparam int MAX_COORD   = (1 << CoordBits) - 1;
	localparam int RANDOM_CMDS = 1600;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

	// Scoreboard: tracks its own copy of the line state, predicts the pixel beat for
	// each command taken, and checks pixel beats in order.
	class line_pixel_checker;
		pix_t                 pending_pixels[$];
		int                   mismatch_count;
		logic [CW-1:0]        pos_x, pos_y, run_end, mirror_row;
		logic signed [DW-1:0] err_term;
		logic signed [IW-1:0] step_flat, step_diag;
		bit                   steep, mirrored, busy;

		function new();
			mismatch_count = 0;
			pos_x = '0;
			pos_y = '0;
			run_end = '0;
			mirror_row = '0;
			err_term = '0;
			step_flat = '0;
			step_diag = '0;
			steep = 1'b0;
			mirrored = 1'b0;
			busy = 1'b0;
		endfunction

		// Queue a predicted pixel beat at the tail.
		function void expect_pixel(pix_t p);
			pending_pixels.insert(pending_pixels.size(), p);
		endfunction

		// Pixel at the current position, mirror undone; the end of the run closes the line.
		function pix_t current_pixel();
			pix_t          p;
			int            oy;
			logic [CW-1:0] major;
			oy = mirrored ? 2 * int'(mirror_row) - int'(pos_y) : int'(pos_y);
			major = steep ? pos_y : pos_x;
			p.pixel_x     = pos_x[CoordBits-1:0];
			p.pixel_y     = oy[CoordBits-1:0];
			p.pixel_valid = 1'b1;
			p.last_pixel  = (major >= run_end);
			busy = !p.last_pixel;
			return p;
		endfunction

		function void take_cmd(cmd_t c);
			int x0, y0, x1, y1, t, dx, dy;
			if (c.action == ACT_LOAD) begin
				x0 = int'(c.start_x);
				y0 = int'(c.start_y);
				x1 = int'(c.end_x);
				y1 = int'(c.end_y);
				// make x rise
				if (x1 < x0) begin
					t = x0; x0 = x1; x1 = t;
					t = y0; y0 = y1; y1 = t;
				end
				dx = x1 - x0;
				mirrored = 1'b0;
				// fold a falling line about the start row
				if (dx > 0 && y1 < y0) begin
					mirrored = 1'b1;
					y1 = 2 * y0 - y1;
				end
				// vertical: walk bottom to top
				if (dx == 0 && y1 < y0) begin
					t = y0; y0 = y1; y1 = t;
				end
				dy = y1 - y0;
				mirror_row = CW'(y0);
				pos_x = CW'(x0);
				pos_y = CW'(y0);
				step_diag = IW'(2 * (dy - dx));
				if (dy > dx) begin
					steep = 1'b1;
					run_end = CW'(y1);
					err_term = DW'(dy - 2 * dx);
					step_flat = IW'(-2 * dx);
				end else begin
					steep = 1'b0;
					run_end = CW'(x1);
					err_term = DW'(2 * dy - dx);
					step_flat = IW'(2 * dy);
				end
				expect_pixel(current_pixel());
			end else if (!busy) begin
				expect_pixel('0);
			end else begin
				if (steep) begin
					if (err_term > 0) begin
						err_term += step_flat;
					end else begin
						err_term += step_diag;
						pos_x++;
					end
					pos_y++;
				end else begin
					if (err_term <= 0) begin
						err_term += step_flat;
					end else begin
						err_term += step_diag;
						pos_y++;
					end
					pos_x++;
				end
				expect_pixel(current_pixel());
			end
		endfunction

		function void check_pixel(pix_t got);
			pix_t want;
			if (pending_pixels.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected pixel beat: x=%0d y=%0d v=%0b last=%0b",
						$realtime, got.pixel_x, got.pixel_y, got.pixel_valid, got.last_pixel);
				mismatch_count++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
				got.pixel_valid !== want.pixel_valid || got.last_pixel !== want.last_pixel) begin
				if (mismatch_count < 10) begin
					$write("%0t: pixel mismatch: expected x=%0d y=%0d v=%0b last=%0b,",
						$realtime, want.pixel_x, want.pixel_y, want.pixel_valid,
						want.last_pixel);
					$display(" got x=%0d y=%0d v=%0b last=%0b",
						got.pixel_x, got.pixel_y, got.pixel_valid, got.last_pixel);
				end
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;

	line_pixel_checker sb;
	int cmds_sent   = 0;
	int burst_left  = 0;
	bit sender_gappy = 1'b1;
	int quiet_cycles = 0;

	midpoint_line_rasterizer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: switch between stall patterns at random intervals, so that stalls
	// land on every phase of the pipeline, with stretches of no stall at all.
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          phase;
		int          run_left;
		bit          hold;
		mode = STALL_NONE;
		mode_left = 0;
		phase = 0;
		run_left = 0;
		hold = 1'b0;
		pix_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				STALL_NONE: begin
					pix_stall <= 1'b0;
				end
				STALL_RANDOM: begin
					pix_stall <= ($urandom_range(0, 2) == 0);
				end
				STALL_PERIODIC: begin
					pix_stall <= ((phase % 7) < 3);
					phase++;
				end
				default: begin
					// alternate long runs of stall and flow
					if (run_left == 0) begin
						run_left = $urandom_range(1, 12);
						hold = !hold;
					end
					run_left--;
					pix_stall <= hold;
				end
			endcase
		end
	end

	// Check every pixel beat the block hands over.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			sb.check_pixel(pix);
	end

	// Watchdog: give up when neither side has moved a beat for too long.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("midpoint_line_rasterizer_core_tb: done, errors");
			$finish;
		end
	end

	// Present one command beat and hold it until taken. Bursts of random length are
	// separated by random gaps when the sender is in its gappy mood.
	task automatic send_cmd(input cmd_t c);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = sender_gappy ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		sb.take_cmd(c);
		cmds_sent++;
	endtask

	// Step beats; the endpoint fields carry junk, which the block must ignore.
	task automatic send_steps(input int n);
		cmd_t c;
		repeat (n) begin
			c.action  = ACT_STEP;
			c.start_x = CoordBits'($urandom);
			c.start_y = CoordBits'($urandom);
			c.end_x   = CoordBits'($urandom);
			c.end_y   = CoordBits'($urandom);
			send_cmd(c);
		end
	endtask

	task automatic send_line(input int x0, input int y0, input int x1, input int y1,
		input int steps);
		cmd_t c;
		c.action  = ACT_LOAD;
		c.start_x = CoordBits'(x0);
		c.start_y = CoordBits'(y0);
		c.end_x   = CoordBits'(x1);
		c.end_y   = CoordBits'(y1);
		send_cmd(c);
		send_steps(steps);
	endtask

	// Drop valid and hold off until every predicted pixel has come back.
	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
	endtask

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
	endfunction

	initial begin
		int  kind, span, steps, len, ax, ay;
		int  x0, y0, x1, y1;
		bit  paused;
		paused = 1'b0;
		sb = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle step, single points at both corners, endpoint swap, a falling
		// steep line at the top edge with a decision tie, a vertical line drawn
		// downward, a shallow tie, a leftward horizontal run, and loads that drop a
		// line part way.
		send_steps(1);
		send_line(0, 0, 0, 0, 1);
		send_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 0);
		send_line(3, 0, 0, 1, 3);
		send_line(0, MAX_COORD, 1, MAX_COORD - 2, 2);
		send_line(5, 9, 5, 7, 2);
		send_line(0, 0, 2, 1, 2);
		send_line(MAX_COORD, 5, MAX_COORD - 2, 5, 2);
		send_line(0, 0, MAX_COORD, MAX_COORD, 1);
		send_line(MAX_COORD, 0, 0, MAX_COORD, 1);
		wait_drained();

		// Random: mostly complete short lines anywhere on the grid, some medium ones,
		// long lines cut short by the next load, axis-aligned runs, and stray steps.
		while (cmds_sent < RANDOM_CMDS) begin
			// hold off once mid-run until the pipeline is empty
			if (!paused && cmds_sent >= RANDOM_CMDS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			sender_gappy = ($urandom_range(0, 9) < 6);
			kind = $urandom_range(0, 99);
			x0 = $urandom_range(0, MAX_COORD);
			y0 = $urandom_range(0, MAX_COORD);
			if (kind >= 96) begin
				send_steps($urandom_range(1, 3));
				continue;
			end
			if (kind < 80) begin
				span = (kind < 70) ? 12 : 60;
				x1 = clamp_coord(x0 + $urandom_range(0, 2 * span) - span);
				y1 = clamp_coord(y0 + $urandom_range(0, 2 * span) - span);
			end else if (kind < 88) begin
				x1 = $urandom_range(0, MAX_COORD);
				y1 = $urandom_range(0, MAX_COORD);
			end else if (kind < 92) begin
				x1 = x0;
				y1 = clamp_coord(y0 + $urandom_range(0, 40) - 20);
			end else begin
				x1 = clamp_coord(x0 + $urandom_range(0, 40) - 20);
				y1 = y0;
			end
			ax = (x1 > x0) ? x1 - x0 : x0 - x1;
			ay = (y1 > y0) ? y1 - y0 : y0 - y1;
			len = (ax > ay) ? ax : ay;
			if (kind >= 80 && kind < 88)
				steps = $urandom_range(0, 30);
			else if ($urandom_range(0, 6) == 0)
				steps = $urandom_range(0, len);
			else
				steps = len + $urandom_range(0, 2);
			send_line(x0, y0, x1, y1, steps);
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending_pixels.size() != 0) begin
			$display("%0d pixel beats never arrived", sb.pending_pixels.size());
			sb.mismatch_count += sb.pending_pixels.size();
		end
		if (sb.mismatch_count == 0)
			$display("midpoint_line_rasterizer_core_tb: done, clean");
		else
			$display("midpoint_line_rasterizer_core_tb: done, errors");
		$finish;
	end

endmodule
